### rtl/subtractive_random_generator_core_macros.svh
// Assertion macros used by the subtractive random generator RTL
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_CORE_MACROS_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_CORE_MACROS_SVH

// check cons in the same cycle whenever ante holds
`define SRG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srg assertion failed");

// check cons in the cycle after ante holds
`define SRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srg assertion failed");

`endif

### rtl/srg_pkg.sv
// Shared types, constants and helpers of the subtractive random generator
package srg_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned IndexWidth = 6;

   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [IndexWidth-1:0] index_type;

   localparam word_type MBIG           = 32'h7FFF_FFFF;
   localparam word_type MBIG_LESS_ONE  = 32'h7FFF_FFFE;
   localparam word_type SEED_DIFFUSER  = 32'd161803398;
   localparam word_type SEED_MOST_NEG  = 32'h8000_0000;
   localparam word_type WORD_ONE       = 32'd1;
   localparam word_type WIDE_BASE      = 32'd2147483646;
   localparam word_type WIDE_DIVISOR   = 32'hFFFF_FFFD;

   localparam index_type INDEX_ZERO    = 6'd0;
   localparam index_type TABLE_FIRST   = 6'd1;
   localparam index_type TABLE_LAST    = 6'd55;
   localparam index_type LAG_START     = 6'd21;
   localparam index_type LAG_WRAP      = 6'd34;
   localparam index_type MIX_START     = 6'd32;
   localparam index_type FILL_LAST     = 6'd53;
   localparam logic [1:0] PASS_FIRST   = 2'd0;
   localparam logic [1:0] PASS_LAST    = 2'd3;

   typedef enum logic [1:0] {
      MODE_RAW,
      MODE_EQUAL,
      MODE_NARROW,
      MODE_WIDE
   } mode_type;

   typedef struct packed {
      mode_type mode;
      word_type lo;
      word_type span;
      word_type sample_a;
      logic     b_odd;
   } srg_beat_type;

   // a negative 32-bit result gets MBIG added once
   function automatic word_type fold_negative(input word_type v);
      return v[WordWidth-1] ? v + MBIG : v;
   endfunction

   function automatic index_type next_index(input index_type v);
      return (v >= TABLE_LAST) ? TABLE_FIRST : v + TABLE_FIRST;
   endfunction

endpackage

### rtl/srg_req_if.sv
// Request channel: valid/ready handshake carrying the request fields
interface srg_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [31:0] min_value;
   logic signed [31:0] max_value;

   modport source (output valid, req_type, min_value, max_value, input ready);
   modport sink (input valid, req_type, min_value, max_value, output ready);
endinterface

### rtl/srg_rsp_if.sv
// Response channel: valid/ready handshake carrying the result value
interface srg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;

   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface

### rtl/srg_map.sv
// Range mapping pipeline: product, division by constant and offset into the result
module srg_map
   import srg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  srg_beat_type     in_beat,
   srg_rsp_if.source        rsp_bus
);

   logic         s2_v_ff;
   srg_beat_type s2_beat_ff;
   logic         s3_v_ff;
   mode_type     s3_mode_ff;
   word_type     s3_lo_ff;
   logic [63:0]  s3_prod_ff;
   logic         s4_v_ff;
   mode_type     s4_mode_ff;
   word_type     s4_lo_ff;
   word_type     s4_high_ff;
   logic [33:0]  s4_sum_ff;
   logic         out_v_ff;
   word_type     out_value_ff;

   logic         out_free;
   logic         s4_free;
   logic         s3_free;
   logic         s2_free;

   logic [33:0]  t_wide;
   word_type     mul_lhs;
   logic [63:0]  mul_full;
   word_type     corr;
   logic [63:0]  s3_prod_in;

   logic [33:0]  sum_narrow;
   logic [33:0]  sum_wide;
   word_type     s4_high_in;
   logic [33:0]  s4_sum_in;

   logic [1:0]   h2_narrow;
   logic [1:0]   h2_wide;
   word_type     z_narrow;
   logic [3:0]   h2_wide_x3;
   logic [32:0]  z_wide;
   logic [1:0]   h2_sel;
   logic         carry_sel;
   word_type     quot;
   word_type     out_value_in;

   // a stage loads whenever it is empty or its content moves on
   assign out_free = !out_v_ff || rsp_bus.ready;
   assign s4_free  = !s4_v_ff || out_free;
   assign s3_free  = !s3_v_ff || s4_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign in_ready = s2_free;

   // stage 2: t for the two-sample case, then the one multiplier
   always_comb begin
      if (s2_beat_ff.b_odd) begin
         t_wide = {2'b00, WIDE_BASE} + {2'b00, s2_beat_ff.sample_a};
      end else begin
         t_wide = {2'b00, WIDE_BASE} - {2'b00, s2_beat_ff.sample_a};
      end
      mul_lhs  = (s2_beat_ff.mode == MODE_WIDE) ? t_wide[31:0] : s2_beat_ff.sample_a;
      mul_full = 64'(mul_lhs) * 64'(s2_beat_ff.span);
      // upper bits of t are -1, 0 or +1: fold them in as a shifted span
      corr = '0;
      if (s2_beat_ff.mode == MODE_WIDE) begin
         if (t_wide[33]) begin
            corr = ~s2_beat_ff.span + WORD_ONE;
         end else if (t_wide[32]) begin
            corr = s2_beat_ff.span;
         end
      end
      if (s2_beat_ff.mode == MODE_RAW) begin
         s3_prod_in = {32'b0, s2_beat_ff.sample_a};
      end else begin
         s3_prod_in = mul_full + {corr, 32'b0};
      end
   end

   // stage 3: first fold of the division by 2^31-1 or 2^32-3
   always_comb begin
      sum_narrow = {2'b00, s3_prod_ff[62:31]} + {3'b000, s3_prod_ff[30:0]};
      sum_wide   = {2'b00, s3_prod_ff[63:32]} + {1'b0, s3_prod_ff[63:32], 1'b0}
                 + {2'b00, s3_prod_ff[31:0]};
      case (s3_mode_ff)
         MODE_RAW: begin
            s4_high_in = s3_prod_ff[31:0];
            s4_sum_in  = '0;
         end
         MODE_NARROW: begin
            s4_high_in = s3_prod_ff[62:31];
            s4_sum_in  = sum_narrow;
         end
         MODE_WIDE: begin
            s4_high_in = s3_prod_ff[63:32];
            s4_sum_in  = sum_wide;
         end
         default: begin
            s4_high_in = '0;
            s4_sum_in  = '0;
         end
      endcase
   end

   // stage 4: second fold, final correction, offset by the lower bound
   always_comb begin
      h2_narrow  = s4_sum_ff[32:31];
      z_narrow   = {30'b0, h2_narrow} + {1'b0, s4_sum_ff[30:0]};
      h2_wide    = s4_sum_ff[33:32];
      h2_wide_x3 = {1'b0, h2_wide, 1'b0} + {2'b00, h2_wide};
      z_wide     = {29'b0, h2_wide_x3} + {1'b0, s4_sum_ff[31:0]};
      if (s4_mode_ff == MODE_WIDE) begin
         h2_sel    = h2_wide;
         carry_sel = (z_wide >= {1'b0, WIDE_DIVISOR});
      end else begin
         h2_sel    = h2_narrow;
         carry_sel = (z_narrow >= MBIG);
      end
      quot = s4_high_ff + {30'b0, h2_sel} + {31'b0, carry_sel};
      case (s4_mode_ff)
         MODE_RAW:   out_value_in = s4_high_ff;
         MODE_EQUAL: out_value_in = s4_lo_ff;
         default:    out_value_in = s4_lo_ff + quot;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s2_free) begin
            s2_v_ff <= in_valid;
         end
         if (s3_free) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s4_free) begin
            s4_v_ff <= s3_v_ff;
         end
         if (out_free) begin
            out_v_ff <= s4_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_beat_ff <= in_beat;
      end
      if (s3_free) begin
         s3_mode_ff <= s2_beat_ff.mode;
         s3_lo_ff   <= s2_beat_ff.lo;
         s3_prod_ff <= s3_prod_in;
      end
      if (s4_free) begin
         s4_mode_ff <= s3_mode_ff;
         s4_lo_ff   <= s3_lo_ff;
         s4_high_ff <= s4_high_in;
         s4_sum_ff  <= s4_sum_in;
      end
      if (out_free) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_bus.valid = out_v_ff;
   assign rsp_bus.value = signed'(out_value_ff);

endmodule

### rtl/subtractive_random_generator_core.sv
// Subtractive random generator core: seeding sequencer, lag table and sample draw
// A request is registered in stage 1, then passes the map stages and the output register.
// One request is taken per cycle while the response side does not stall; a range wider than 2^31-1
// holds stage 1 for a second draw, since each sample is one read-modify-write of the 55-entry lag
// table through its single write port. Reset or a seed write starts seeding (load, fill, four mix
// passes over the 55 entries, drain) with req ready low; csr writes are taken at any time.
`include "subtractive_random_generator_core_macros.svh"
module subtractive_random_generator_core
   import srg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [31:0] csr_wr_data,
   srg_req_if.sink            req_bus,
   srg_rsp_if.source          rsp_bus
);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_FILL  = 5'b00010,
      ST_MIX   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_RUN   = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   word_type     seed_ff, seed_in;
   index_type    front_ff, front_in;
   index_type    back_ff, back_in;
   word_type     cur_ff, cur_in;
   word_type     prev_ff, prev_in;
   index_type    pos_ff, pos_in;
   index_type    fill_cnt_ff, fill_cnt_in;
   index_type    mix_k_ff, mix_k_in;
   index_type    mix_j_ff, mix_j_in;
   logic [1:0]   pass_ff, pass_in;
   logic         mix_wr_ff, mix_wr_in;
   index_type    mix_addr_ff, mix_addr_in;

   word_type     lag_mem [TABLE_FIRST:TABLE_LAST];
   word_type     rd_f_ff, rd_b_ff;
   index_type    rd_f_addr, rd_b_addr;
   logic         wr_en;
   index_type    wr_addr;
   word_type     wr_data;

   logic         s1_v_ff, s1_v_in;
   logic         s1_half_ff, s1_half_in;
   logic         s1_type_ff;
   word_type     s1_lo_ff;
   word_type     s1_hi_ff;
   word_type     s1_a_ff;

   word_type     seed_mag;
   word_type     seed_cur0;
   word_type     diff;
   word_type     diff_lim;
   word_type     sample;
   word_type     mix_value;
   logic         lo_gt_hi;
   word_type     hi_eff;
   logic [32:0]  span_ext;
   word_type     s1_span;
   mode_type     s1_mode;
   logic         run;
   logic         first_draw;
   logic         s1_go;
   logic         draw;
   logic         accept;
   logic         map_valid;
   logic         map_ready;
   srg_beat_type map_beat;
   logic         lag_ok;

   assign run = (state_ff == ST_RUN);

   // seed magnitude, most negative seed taken as MBIG
   always_comb begin
      if (seed_ff == SEED_MOST_NEG) begin
         seed_mag = MBIG;
      end else if (seed_ff[WordWidth-1]) begin
         seed_mag = ~seed_ff + WORD_ONE;
      end else begin
         seed_mag = seed_ff;
      end
      seed_cur0 = SEED_DIFFUSER - seed_mag;
   end

   // one difference of the two prefetched entries serves mixing and sampling
   always_comb begin
      diff      = rd_f_ff - rd_b_ff;
      diff_lim  = (diff == MBIG) ? MBIG_LESS_ONE : diff;
      sample    = fold_negative(diff_lim);
      mix_value = fold_negative(diff);
   end

   // stage 1: classify the held request and draw its samples
   always_comb begin
      lo_gt_hi = $signed(s1_lo_ff) > $signed(s1_hi_ff);
      hi_eff   = lo_gt_hi ? s1_lo_ff : s1_hi_ff;
      span_ext = {hi_eff[WordWidth-1], hi_eff} - {s1_lo_ff[WordWidth-1], s1_lo_ff};
      s1_span  = span_ext[31:0];
      if (!s1_type_ff) begin
         s1_mode = MODE_RAW;
      end else if (s1_lo_ff == s1_hi_ff) begin
         s1_mode = MODE_EQUAL;
      end else if (s1_span[WordWidth-1]) begin
         s1_mode = MODE_WIDE;
      end else begin
         s1_mode = MODE_NARROW;
      end
      first_draw = run && s1_v_ff && (s1_mode == MODE_WIDE) && !s1_half_ff;
      map_valid  = run && s1_v_ff && !first_draw;
      s1_go      = map_valid && map_ready;
      draw       = first_draw || (s1_go && (s1_mode != MODE_EQUAL));

      map_beat.mode     = s1_mode;
      map_beat.lo       = s1_lo_ff;
      map_beat.span     = s1_span;
      map_beat.sample_a = (s1_mode == MODE_WIDE) ? s1_a_ff : sample;
      map_beat.b_odd    = sample[0];
   end

   assign req_bus.ready = run && (!s1_v_ff || s1_go);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_v_in    = s1_v_ff;
      s1_half_in = s1_half_ff;
      if (first_draw) begin
         s1_half_in = 1'b1;
      end
      if (s1_go) begin
         s1_v_in    = 1'b0;
         s1_half_in = 1'b0;
      end
      if (accept) begin
         s1_v_in    = 1'b1;
         s1_half_in = 1'b0;
      end
   end

   // seeding sequencer and table write port
   always_comb begin
      state_in    = state_ff;
      seed_in     = seed_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      pos_in      = pos_ff;
      fill_cnt_in = fill_cnt_ff;
      mix_k_in    = mix_k_ff;
      mix_j_in    = mix_j_ff;
      pass_in     = pass_ff;
      mix_wr_in   = 1'b0;
      mix_addr_in = mix_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = TABLE_LAST;
      wr_data     = '0;
      case (state_ff)
         ST_LOAD: begin
            wr_en       = 1'b1;
            wr_addr     = TABLE_LAST;
            wr_data     = seed_cur0;
            cur_in      = seed_cur0;
            prev_in     = WORD_ONE;
            pos_in      = LAG_START;
            fill_cnt_in = INDEX_ZERO;
            front_in    = INDEX_ZERO;
            back_in     = LAG_START;
            state_in    = ST_FILL;
         end
         ST_FILL: begin
            wr_en       = 1'b1;
            wr_addr     = pos_ff;
            wr_data     = prev_ff;
            prev_in     = fold_negative(cur_ff - prev_ff);
            cur_in      = prev_ff;
            pos_in      = (pos_ff >= LAG_WRAP) ? pos_ff - LAG_WRAP : pos_ff + LAG_START;
            fill_cnt_in = fill_cnt_ff + TABLE_FIRST;
            if (fill_cnt_ff == FILL_LAST) begin
               mix_k_in = TABLE_FIRST;
               mix_j_in = MIX_START;
               pass_in  = PASS_FIRST;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // write back the entry whose read was issued in the previous cycle
            wr_en       = mix_wr_ff;
            wr_addr     = mix_addr_ff;
            wr_data     = mix_value;
            mix_wr_in   = 1'b1;
            mix_addr_in = mix_k_ff;
            mix_k_in    = next_index(mix_k_ff);
            mix_j_in    = next_index(mix_j_ff);
            if (mix_k_ff == TABLE_LAST) begin
               pass_in = pass_ff + 2'd1;
               if (pass_ff == PASS_LAST) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            wr_en    = mix_wr_ff;
            wr_addr  = mix_addr_ff;
            wr_data  = mix_value;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (draw) begin
               wr_en    = 1'b1;
               wr_addr  = next_index(front_ff);
               wr_data  = sample;
               front_in = next_index(front_ff);
               back_in  = next_index(back_ff);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (csr_wr_en) begin
         seed_in  = word_type'(csr_wr_data);
         state_in = ST_LOAD;
      end
   end

   // prefetch the pair for the next sample, or the pair the mix pass needs
   always_comb begin
      if (state_ff == ST_MIX) begin
         rd_f_addr = mix_k_ff;
         rd_b_addr = mix_j_ff;
      end else begin
         rd_f_addr = next_index(front_in);
         rd_b_addr = next_index(back_in);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lag_mem[wr_addr] <= wr_data;
      end
      rd_f_ff <= lag_mem[rd_f_addr];
      rd_b_ff <= lag_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         seed_ff    <= '0;
         front_ff   <= INDEX_ZERO;
         back_ff    <= LAG_START;
         mix_wr_ff  <= 1'b0;
         s1_v_ff    <= 1'b0;
         s1_half_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         seed_ff    <= seed_in;
         front_ff   <= front_in;
         back_ff    <= back_in;
         mix_wr_ff  <= mix_wr_in;
         s1_v_ff    <= s1_v_in;
         s1_half_ff <= s1_half_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      pos_ff      <= pos_in;
      fill_cnt_ff <= fill_cnt_in;
      mix_k_ff    <= mix_k_in;
      mix_j_ff    <= mix_j_in;
      pass_ff     <= pass_in;
      mix_addr_ff <= mix_addr_in;
      if (accept) begin
         s1_type_ff <= req_bus.req_type;
         s1_lo_ff   <= word_type'(req_bus.min_value);
         s1_hi_ff   <= word_type'(req_bus.max_value);
      end
      if (first_draw) begin
         s1_a_ff <= sample;
      end
   end

   srg_map u_map (
      .clock    (clock),
      .reset    (reset),
      .in_valid (map_valid),
      .in_ready (map_ready),
      .in_beat  (map_beat),
      .rsp_bus  (rsp_bus)
   );

   // back index leads the front index by 21, wrapped into 1..55
   assign lag_ok = ((front_ff <= LAG_WRAP) && (back_ff == front_ff + LAG_START))
                || ((front_ff > LAG_WRAP) && (back_ff == front_ff - LAG_WRAP));

   `SRG_ASSERT_IMPLY(a_lag_spacing, clock, reset, state_ff == ST_RUN, lag_ok)
   `SRG_ASSERT_NEXT(a_csr_reseeds, clock, reset, csr_wr_en, state_ff == ST_LOAD)
   `SRG_ASSERT_NEXT(a_wide_second_draw, clock, reset, first_draw, s1_v_ff && s1_half_ff)

endmodule
